FILE: design/assert_macros.svh
// Assertion macros shared by the RTL files of the scheduler.
// Needs nothing else; each file that asserts includes it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define PIS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PIS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/pis_pkg.sv
// Package for the priority interleave scheduler: widths, level codes and helpers.
// Used by the channel interfaces and the top level.
`default_nettype none

package pis_pkg;

    localparam int MAX_NODES_DEF = 16;

    localparam int CMD_W   = 1;
    localparam int NODE_W  = 4;
    localparam int LEVEL_W = 3;
    localparam int GRANT_W = 4;
    localparam int LOOP_W  = 32;
    localparam int CFG_W   = 5;

    localparam logic [CMD_W-1:0] CMD_NEXT      = 1'b0;
    localparam logic [CMD_W-1:0] CMD_SET_LEVEL = 1'b1;

    localparam logic [LEVEL_W-1:0] LVL_P3 = 3'b011;
    localparam logic [LEVEL_W-1:0] LVL_P2 = 3'b010;
    localparam logic [LEVEL_W-1:0] LVL_P1 = 3'b001;
    localparam logic [LEVEL_W-1:0] LVL_Z  = 3'b000;
    localparam logic [LEVEL_W-1:0] LVL_M1 = 3'b111;
    localparam logic [LEVEL_W-1:0] LVL_M2 = 3'b110;

    // Order in which the non-group levels are interleaved.
    function automatic logic [LEVEL_W-1:0] phase_level(input logic [1:0] phase);
        logic [LEVEL_W-1:0] lv;
        case (phase)
            2'd0:    lv = LVL_P1;
            2'd1:    lv = LVL_Z;
            2'd2:    lv = LVL_M1;
            default: lv = LVL_M2;
        endcase
        return lv;
    endfunction

endpackage

`default_nettype wire

FILE: design/pis_req_if.sv
// Request channel of the scheduler: valid, ready and the command payload.
// Depends on pis_pkg for the field widths.
`default_nettype none

interface pis_req_if;
    import pis_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [CMD_W-1:0]          cmd;
    logic [NODE_W-1:0]         node;
    logic signed [LEVEL_W-1:0] level;

    modport source (output valid, output cmd, output node, output level, input ready);
    modport sink   (input valid, input cmd, input node, input level, output ready);
endinterface

`default_nettype wire

FILE: design/pis_rsp_if.sv
// Response channel of the scheduler: valid, ready and the grant payload.
// Depends on pis_pkg for the field widths.
`default_nettype none

interface pis_rsp_if;
    import pis_pkg::*;

    logic               valid;
    logic               ready;
    logic [GRANT_W-1:0] granted;
    logic               none_ready;
    logic [LOOP_W-1:0]  loop_count;

    modport source (output valid, output granted, output none_ready, output loop_count,
                    input ready);
    modport sink   (input valid, input granted, input none_ready, input loop_count,
                    output ready);
endinterface

`default_nettype wire

FILE: design/priority_interleave_scheduler_top.sv
// Top level of the priority interleave scheduler: sequencer, level tables, sequence memory.
// Depends on pis_pkg, pis_req_if, pis_rsp_if and assert_macros.svh.
//
//   channel | role    | payload
//   req     | sink    | cmd, node, level
//   rsp     | source  | granted, none_ready, loop_count
//   cfg     | write   | active_nodes (cfg_we, cfg_wdata)
//
// A set_level request updates the level table on acceptance. A next request without a rebuild
// scans the n node levels for changes (n the registered node count), then reads the sequence
// at the cursor, rereading past skipped entries. A rebuild lays down P3 nodes; with none, it
// walks the table once per other non-group level and runs the group scan per node found, or
// once if none, all via the single level table read port. Reset is asynchronous; no clearing
// pass is needed. The sequencer waits for a pending response to be taken only at request end.
`default_nettype none

module priority_interleave_scheduler_top #(
    parameter int MAX_NODES = pis_pkg::MAX_NODES_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic [pis_pkg::CFG_W-1:0] cfg_wdata,
    pis_req_if.sink                       req,
    pis_rsp_if.source                     rsp
);
    import pis_pkg::*;
    `include "assert_macros.svh"

    localparam int IDX_W     = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CNT_W     = $clog2(MAX_NODES + 1);
    localparam int SEQ_DEPTH = ((MAX_NODES + 1) * (MAX_NODES + 1)) / 4 + 1;
    localparam int SEQ_AW    = $clog2(SEQ_DEPTH);
    localparam int LEN_W     = $clog2(SEQ_DEPTH + 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHG,
        ST_REB3,
        ST_REBX,
        ST_REBG,
        ST_REB_END,
        ST_FIRST,
        ST_SK_WRAP,
        ST_SK_RD,
        ST_SK_CHK,
        ST_DELIVER
    } state_t;

    state_t               state_reg, state_next;
    logic [CFG_W-1:0]     active_reg;
    logic [LEVEL_W-1:0]   node_level_reg [MAX_NODES];
    logic [LEVEL_W-1:0]   node_level_next [MAX_NODES];
    logic [LEVEL_W-1:0]   seen_level_reg [MAX_NODES];
    logic [LEVEL_W-1:0]   seen_level_next [MAX_NODES];
    logic [LEN_W-1:0]     len_reg, len_next;
    logic [LEN_W-1:0]     cursor_reg, cursor_next;
    logic [LOOP_W-1:0]    pass_reg, pass_next;
    logic [1:0]           res3_reg, res3_next;
    logic [2:0]           res5_reg, res5_next;
    logic [CNT_W-1:0]     i_reg, i_next;
    logic [CNT_W-1:0]     j_reg, j_next;
    logic [1:0]           phase_reg, phase_next;
    logic                 changed_reg, changed_next;
    logic                 found_reg, found_next;
    logic                 xflag_reg, xflag_next;
    logic [GRANT_W-1:0]   res_grant_reg, res_grant_next;
    logic                 res_none_reg, res_none_next;
    logic                 out_valid_reg, out_valid_next;
    logic [GRANT_W-1:0]   out_grant_reg, out_grant_next;
    logic                 out_none_reg, out_none_next;
    logic [LOOP_W-1:0]    out_loop_reg, out_loop_next;

    logic [IDX_W-1:0]     seq_mem [SEQ_DEPTH];
    logic                 mem_we;
    logic [SEQ_AW-1:0]    mem_wa;
    logic [IDX_W-1:0]     mem_wd;
    logic [SEQ_AW-1:0]    mem_ra;
    logic [IDX_W-1:0]     mem_rd;

    logic [CNT_W-1:0]     n_cnt;
    logic [IDX_W-1:0]     lvl_addr;
    logic [LEVEL_W-1:0]   lvl_rd;
    logic [LOOP_W-1:0]    pass_inc;
    logic [1:0]           res3_inc;
    logic [2:0]           res5_inc;
    logic                 emit_ok;

    assign n_cnt = (int'(active_reg) > MAX_NODES) ? CNT_W'(MAX_NODES) : CNT_W'(active_reg);

    // One read port into the level table, shared by the scans and the skip check.
    always_comb
    begin
        case (state_reg)
            ST_REBG:   lvl_addr = j_reg[IDX_W-1:0];
            ST_SK_CHK: lvl_addr = mem_rd;
            default:   lvl_addr = i_reg[IDX_W-1:0];
        endcase
    end
    assign lvl_rd = node_level_reg[lvl_addr];

    assign pass_inc = pass_reg + LOOP_W'(1);
    assign res3_inc = (pass_inc == '0) ? 2'd0 : ((res3_reg == 2'd2) ? 2'd0 : res3_reg + 2'd1);
    assign res5_inc = (pass_inc == '0) ? 3'd0 : ((res5_reg == 3'd4) ? 3'd0 : res5_reg + 3'd1);
    assign emit_ok  = len_reg < LEN_W'(SEQ_DEPTH);

    assign req.ready      = (state_reg == ST_IDLE);
    assign rsp.valid      = out_valid_reg;
    assign rsp.granted    = out_grant_reg;
    assign rsp.none_ready = out_none_reg;
    assign rsp.loop_count = out_loop_reg;

    always_comb
    begin
        state_next      = state_reg;
        node_level_next = node_level_reg;
        seen_level_next = seen_level_reg;
        len_next        = len_reg;
        cursor_next     = cursor_reg;
        pass_next       = pass_reg;
        res3_next       = res3_reg;
        res5_next       = res5_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        phase_next      = phase_reg;
        changed_next    = changed_reg;
        found_next      = found_reg;
        xflag_next      = xflag_reg;
        res_grant_next  = res_grant_reg;
        res_none_next   = res_none_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_grant_next  = out_grant_reg;
        out_none_next   = out_none_reg;
        out_loop_next   = out_loop_reg;
        mem_we          = 1'b0;
        mem_wa          = len_reg[SEQ_AW-1:0];
        mem_wd          = i_reg[IDX_W-1:0];
        mem_ra          = cursor_reg[SEQ_AW-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.cmd == CMD_SET_LEVEL)
                    begin
                        if (int'(req.node) < MAX_NODES)
                        begin
                            node_level_next[IDX_W'(req.node)] = req.level;
                        end
                    end
                    else
                    begin
                        if (cursor_reg >= len_reg)
                        begin
                            cursor_next = '0;
                            pass_next   = pass_inc;
                            res3_next   = res3_inc;
                            res5_next   = res5_inc;
                        end
                        i_next       = '0;
                        changed_next = 1'b0;
                        state_next   = ST_CHG;
                    end
                end
            end
            ST_CHG:
            begin
                if (i_reg == n_cnt)
                begin
                    if (changed_reg || (cursor_reg >= len_reg))
                    begin
                        i_next      = '0;
                        len_next    = '0;
                        cursor_next = '0;
                        state_next  = ST_REB3;
                    end
                    else
                    begin
                        state_next = ST_SK_RD;
                    end
                end
                else
                begin
                    if (lvl_rd != seen_level_reg[i_reg[IDX_W-1:0]])
                    begin
                        seen_level_next[i_reg[IDX_W-1:0]] = lvl_rd;
                        changed_next = 1'b1;
                    end
                    i_next = i_reg + CNT_W'(1);
                end
            end
            ST_REB3:
            begin
                if (i_reg == n_cnt)
                begin
                    i_next     = '0;
                    phase_next = 2'd0;
                    found_next = 1'b0;
                    state_next = (len_reg != '0) ? ST_REB_END : ST_REBX;
                end
                else
                begin
                    if (lvl_rd == LVL_P3 && emit_ok)
                    begin
                        mem_we   = 1'b1;
                        len_next = len_reg + LEN_W'(1);
                    end
                    i_next = i_reg + CNT_W'(1);
                end
            end
            ST_REBX:
            begin
                if (i_reg == n_cnt)
                begin
                    if (phase_reg == 2'd3)
                    begin
                        // With no other nodes at all the group is laid down once.
                        j_next     = '0;
                        xflag_next = 1'b0;
                        state_next = found_reg ? ST_REB_END : ST_REBG;
                    end
                    else
                    begin
                        phase_next = phase_reg + 2'd1;
                        i_next     = '0;
                    end
                end
                else if (lvl_rd == phase_level(phase_reg))
                begin
                    found_next = 1'b1;
                    j_next     = '0;
                    xflag_next = 1'b1;
                    state_next = ST_REBG;
                end
                else
                begin
                    i_next = i_reg + CNT_W'(1);
                end
            end
            ST_REBG:
            begin
                if (j_reg == n_cnt)
                begin
                    if (xflag_reg)
                    begin
                        if (emit_ok)
                        begin
                            mem_we   = 1'b1;
                            len_next = len_reg + LEN_W'(1);
                        end
                        i_next     = i_reg + CNT_W'(1);
                        state_next = ST_REBX;
                    end
                    else
                    begin
                        state_next = ST_REB_END;
                    end
                end
                else
                begin
                    if (lvl_rd == LVL_P2 && emit_ok)
                    begin
                        mem_we   = 1'b1;
                        mem_wd   = j_reg[IDX_W-1:0];
                        len_next = len_reg + LEN_W'(1);
                    end
                    j_next = j_reg + CNT_W'(1);
                end
            end
            ST_REB_END:
            begin
                mem_ra = '0;
                if (len_reg == '0)
                begin
                    res_grant_next = '0;
                    res_none_next  = 1'b1;
                    state_next     = ST_DELIVER;
                end
                else
                begin
                    state_next = ST_FIRST;
                end
            end
            ST_FIRST:
            begin
                res_grant_next = GRANT_W'(mem_rd);
                res_none_next  = 1'b0;
                cursor_next    = LEN_W'(1);
                state_next     = ST_DELIVER;
            end
            ST_SK_WRAP:
            begin
                if (cursor_reg >= len_reg)
                begin
                    cursor_next = '0;
                    pass_next   = pass_inc;
                    res3_next   = res3_inc;
                    res5_next   = res5_inc;
                end
                state_next = ST_SK_RD;
            end
            ST_SK_RD:
            begin
                mem_ra      = cursor_reg[SEQ_AW-1:0];
                cursor_next = cursor_reg + LEN_W'(1);
                state_next  = ST_SK_CHK;
            end
            ST_SK_CHK:
            begin
                if ((lvl_rd == LVL_M1 && res3_reg != 2'd0) ||
                    (lvl_rd == LVL_M2 && res5_reg != 3'd0))
                begin
                    state_next = ST_SK_WRAP;
                end
                else
                begin
                    res_grant_next = GRANT_W'(mem_rd);
                    res_none_next  = 1'b0;
                    state_next     = ST_DELIVER;
                end
            end
            ST_DELIVER:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_grant_next = res_grant_reg;
                    out_none_next  = res_none_reg;
                    out_loop_next  = pass_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            seq_mem[mem_wa] <= mem_wd;
        end
        mem_rd <= seq_mem[mem_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            active_reg     <= '0;
            node_level_reg <= '{default: '0};
            seen_level_reg <= '{default: '0};
            len_reg        <= '0;
            cursor_reg     <= '0;
            pass_reg       <= '0;
            res3_reg       <= '0;
            res5_reg       <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            phase_reg      <= '0;
            changed_reg    <= 1'b0;
            found_reg      <= 1'b0;
            xflag_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            if (cfg_we)
            begin
                active_reg <= cfg_wdata;
            end
            node_level_reg <= node_level_next;
            seen_level_reg <= seen_level_next;
            len_reg        <= len_next;
            cursor_reg     <= cursor_next;
            pass_reg       <= pass_next;
            res3_reg       <= res3_next;
            res5_reg       <= res5_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            phase_reg      <= phase_next;
            changed_reg    <= changed_next;
            found_reg      <= found_next;
            xflag_reg      <= xflag_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_grant_reg <= res_grant_next;
        res_none_reg  <= res_none_next;
        out_grant_reg <= out_grant_next;
        out_none_reg  <= out_none_next;
        out_loop_reg  <= out_loop_next;
    end

    `PIS_ASSERT(a_cursor_in_seq, clk, rst_n, (state_reg != ST_IDLE) || (cursor_reg <= len_reg), "cursor beyond sequence end while idle")
    `PIS_ASSERT(a_write_in_rebuild, clk, rst_n, !mem_we || ((state_reg == ST_REB3 || state_reg == ST_REBG) && emit_ok), "sequence write outside rebuild")
    `PIS_ASSERT(a_none_zero, clk, rst_n, !(out_valid_reg && out_none_reg) || (out_grant_reg == '0), "empty response carries a grant")
    `PIS_ASSERT_NEXT(a_residue_sync, clk, rst_n, (pass_reg == '0), (res3_reg == 2'd0) && (res5_reg == 3'd0) || (pass_reg == LOOP_W'(1)) || (pass_reg == '0), "residues out of step with pass count")

endmodule

`default_nettype wire
